[hw/rtl/srrw_pkg.sv]
// Shared types and constants of the selective-repeat receive window.
`default_nettype none
package srrw_pkg;

    // Number of buffer slots; a power of two so that the slot of a number is its low bits.
    localparam int DEPTH  = 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int SEQ_W  = 32;
    localparam int PAY_W  = 64;
    localparam int LEN_W  = 11;
    localparam int WIN_W  = 5;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_RR      = 2'd1,
        KIND_SREJ    = 2'd2,
        KIND_EOFACK  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOOKUP,
        S_DRAIN,
        S_TAIL
    } t_state;

    // Where an arriving sequence number falls relative to the window.
    typedef struct packed {
        logic behind;
        logic at_exp;
        logic ahead;
    } t_class;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [LEN_W-1:0] len;
        logic             eof;
    } t_slot;

endpackage
`default_nettype wire

[hw/rtl/srrw_classify.sv]
// Window position compare of an arriving sequence number.
`default_nettype none
module srrw_classify (
    input  wire logic [srrw_pkg::SEQ_W-1:0] i_seq,
    input  wire logic [srrw_pkg::SEQ_W-1:0] i_exp,
    input  wire logic [srrw_pkg::WIN_W-1:0] i_win,
    output srrw_pkg::t_class                o_class
);

    logic [srrw_pkg::SEQ_W:0] w_win_eff;
    logic [srrw_pkg::SEQ_W:0] w_edge;

    always_comb begin
        // A window wider than the slot array acts as the slot array.
        if ({{(srrw_pkg::SEQ_W+1-srrw_pkg::WIN_W){1'b0}}, i_win} >
                (srrw_pkg::SEQ_W+1)'(srrw_pkg::DEPTH)) begin
            w_win_eff = (srrw_pkg::SEQ_W+1)'(srrw_pkg::DEPTH);
        end else begin
            w_win_eff = {{(srrw_pkg::SEQ_W+1-srrw_pkg::WIN_W){1'b0}}, i_win};
        end
        // The edge is formed without wrap, so near the top of the number space the window does not reach past zero.
        w_edge = {1'b0, i_exp} + w_win_eff;
        o_class.behind = (i_seq < i_exp);
        o_class.at_exp = (i_seq == i_exp);
        o_class.ahead  = (i_seq > i_exp) && ({1'b0, i_seq} < w_edge);
    end

endmodule
`default_nettype wire

[hw/rtl/selective_repeat_receive_window_core.sv]
// Top level of the selective-repeat receive window.
`default_nettype none
// Receiver side of a selective-repeat ARQ window. Each input beat is one arriving packet;
// each output beat is one result: a delivered payload, an RR, an SREJ or an EOF ack, with
// o_last marking the final result of a packet. Packets with a bad checksum or beyond the
// window produce nothing. Packets ahead of the expected number are held in a 16-slot
// buffer memory (one read and one write port, registered read data) indexed by the low
// bits of the sequence number; filled and SREJ-sent flags live in flip-flops cleared by
// reset. One packet is handled at a time. A dropped, late or out-of-order packet only
// passes the decide step. An in-order packet is delivered in the decide step; then, for
// each buffered packet it releases, a lookup step checks its flag and reads the buffer
// memory and a drain step presents it; a final lookup finds the next slot empty and a
// tail step sends the RR. If the packet itself or the last released one is an end-of-file
// packet, the final lookup is skipped and the tail step sends the EOF ack. A stalled
// output stalls the sequencer. A finished result may wait in the output register
// while a new packet is being accepted. The window_size register sits at byte address 0
// of the APB port; it must only be written while the block is idle.
module selective_repeat_receive_window_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // Packet input channel.
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [srrw_pkg::SEQ_W-1:0]    i_seq,
    input  wire logic                          i_checksum_ok,
    input  wire logic                          i_is_eof,
    input  wire logic [srrw_pkg::PAY_W-1:0]    i_payload,
    input  wire logic [srrw_pkg::LEN_W-1:0]    i_payload_len,
    // Result output channel.
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [1:0]                    o_kind,
    output logic      [srrw_pkg::SEQ_W-1:0]    o_ack_seq,
    output logic      [srrw_pkg::PAY_W-1:0]    o_out_payload,
    output logic      [srrw_pkg::LEN_W-1:0]    o_out_len,
    output logic                               o_out_eof,
    output logic                               o_last
);

    // Control state.
    srrw_pkg::t_state                 r_state;
    srrw_pkg::t_state                 n_state;
    logic [srrw_pkg::SEQ_W-1:0]       r_exp;
    logic [srrw_pkg::WIN_W-1:0]       r_win;
    logic [srrw_pkg::DEPTH-1:0]       r_filled;
    logic [srrw_pkg::DEPTH-1:0]       r_srej;
    logic                             r_tail_eof;
    logic                             n_tail_eof;

    // Latched input beat.
    logic [srrw_pkg::SEQ_W-1:0]       r_in_seq;
    logic                             r_in_ok;
    logic                             r_in_eof;
    logic [srrw_pkg::PAY_W-1:0]       r_in_payload;
    logic [srrw_pkg::LEN_W-1:0]       r_in_len;

    // Slot buffer memory and its registered read data.
    srrw_pkg::t_slot                  r_mem [srrw_pkg::DEPTH];
    srrw_pkg::t_slot                  r_rd_data;

    // Output register.
    logic                             r_out_valid;
    srrw_pkg::t_kind                  r_out_kind;
    logic [srrw_pkg::SEQ_W-1:0]       r_out_ack;
    logic [srrw_pkg::PAY_W-1:0]       r_out_payload;
    logic [srrw_pkg::LEN_W-1:0]       r_out_len;
    logic                             r_out_eof;
    logic                             r_out_last;

    // Combinational control.
    srrw_pkg::t_class                 w_class;
    logic [srrw_pkg::SLOT_W-1:0]      w_slot_exp;
    logic [srrw_pkg::SLOT_W-1:0]      w_slot_in;
    logic                             w_out_ok;
    logic                             w_in_acc;
    logic                             w_cfg_wr;
    logic                             w_emit;
    srrw_pkg::t_kind                  w_kind;
    logic [srrw_pkg::SEQ_W-1:0]       w_ack;
    logic [srrw_pkg::PAY_W-1:0]       w_pay;
    logic [srrw_pkg::LEN_W-1:0]       w_len;
    logic                             w_eof;
    logic                             w_last;
    logic                             w_exp_inc;
    logic                             w_clr;
    logic                             w_set_srej;
    logic                             w_fill;
    logic                             w_rd;
    logic                             w_tail_load;

    assign w_slot_exp = r_exp[srrw_pkg::SLOT_W-1:0];
    assign w_slot_in  = r_in_seq[srrw_pkg::SLOT_W-1:0];
    // The output register can take a new result when it is empty or being drained now.
    assign w_out_ok   = !r_out_valid || i_ready;
    assign w_in_acc   = i_valid && o_ready;
    // No packet is taken while reset is held.
    assign o_ready    = i_rst_n && (r_state == srrw_pkg::S_IDLE);

    // APB register access; only word 0 holds a register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {{(32-srrw_pkg::WIN_W){1'b0}}, r_win} : 32'd0;

    srrw_classify u_classify (
        .i_seq   (r_in_seq),
        .i_exp   (r_exp),
        .i_win   (r_win),
        .o_class (w_class)
    );

    // Next state and per-cycle actions of the packet sequencer.
    always_comb begin
        n_state     = r_state;
        n_tail_eof  = r_tail_eof;
        w_tail_load = 1'b0;
        w_emit      = 1'b0;
        w_kind      = srrw_pkg::KIND_RR;
        w_ack       = '0;
        w_pay       = '0;
        w_len       = '0;
        w_eof       = 1'b0;
        w_last      = 1'b0;
        w_exp_inc   = 1'b0;
        w_clr       = 1'b0;
        w_set_srej  = 1'b0;
        w_fill      = 1'b0;
        w_rd        = 1'b0;
        case (r_state)
            srrw_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = srrw_pkg::S_DECIDE;
                end
            end
            srrw_pkg::S_DECIDE: begin
                if (!r_in_ok) begin
                    n_state = srrw_pkg::S_IDLE;
                end else if (w_out_ok) begin
                    n_state = srrw_pkg::S_IDLE;
                    if (w_class.behind) begin
                        w_emit = 1'b1;
                        w_kind = srrw_pkg::KIND_RR;
                        w_ack  = r_exp;
                        w_last = 1'b1;
                    end else if (w_class.at_exp) begin
                        // Deliver the arriving packet and retire its slot.
                        w_emit      = 1'b1;
                        w_kind      = srrw_pkg::KIND_DELIVER;
                        w_pay       = r_in_payload;
                        w_len       = r_in_len;
                        w_eof       = r_in_eof;
                        w_clr       = 1'b1;
                        w_exp_inc   = 1'b1;
                        w_tail_load = 1'b1;
                        n_tail_eof  = r_in_eof;
                        n_state     = r_in_eof ? srrw_pkg::S_TAIL : srrw_pkg::S_LOOKUP;
                    end else if (w_class.ahead) begin
                        w_fill = !r_filled[w_slot_in];
                        if (!r_srej[w_slot_exp]) begin
                            w_emit     = 1'b1;
                            w_kind     = srrw_pkg::KIND_SREJ;
                            w_ack      = r_exp;
                            w_last     = 1'b1;
                            w_set_srej = 1'b1;
                        end
                    end
                end
            end
            srrw_pkg::S_LOOKUP: begin
                if (r_filled[w_slot_exp]) begin
                    w_rd    = 1'b1;
                    n_state = srrw_pkg::S_DRAIN;
                end else begin
                    w_tail_load = 1'b1;
                    n_tail_eof  = 1'b0;
                    n_state     = srrw_pkg::S_TAIL;
                end
            end
            srrw_pkg::S_DRAIN: begin
                if (w_out_ok) begin
                    w_emit    = 1'b1;
                    w_kind    = srrw_pkg::KIND_DELIVER;
                    w_pay     = r_rd_data.payload;
                    w_len     = r_rd_data.len;
                    w_eof     = r_rd_data.eof;
                    w_clr     = 1'b1;
                    w_exp_inc = 1'b1;
                    if (r_rd_data.eof) begin
                        w_tail_load = 1'b1;
                        n_tail_eof  = 1'b1;
                        n_state     = srrw_pkg::S_TAIL;
                    end else begin
                        n_state = srrw_pkg::S_LOOKUP;
                    end
                end
            end
            srrw_pkg::S_TAIL: begin
                if (w_out_ok) begin
                    w_emit  = 1'b1;
                    w_kind  = r_tail_eof ? srrw_pkg::KIND_EOFACK : srrw_pkg::KIND_RR;
                    w_ack   = r_tail_eof ? '0 : r_exp;
                    w_last  = 1'b1;
                    n_state = srrw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srrw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srrw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state: expected number, per-slot flags and the window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp      <= '0;
            r_win      <= srrw_pkg::WIN_W'(16);
            r_filled   <= '0;
            r_srej     <= '0;
            r_tail_eof <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_win <= pwdata[srrw_pkg::WIN_W-1:0];
            end
            if (w_exp_inc) begin
                r_exp <= r_exp + 32'd1;
            end
            if (w_tail_load) begin
                r_tail_eof <= n_tail_eof;
            end
            if (w_clr) begin
                r_filled[w_slot_exp] <= 1'b0;
                r_srej[w_slot_exp]   <= 1'b0;
            end
            if (w_set_srej) begin
                r_srej[w_slot_exp] <= 1'b1;
            end
            if (w_fill) begin
                r_filled[w_slot_in] <= 1'b1;
            end
        end
    end

    // Input beat capture.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_seq     <= i_seq;
            r_in_ok      <= i_checksum_ok;
            r_in_eof     <= i_is_eof;
            r_in_payload <= i_payload;
            r_in_len     <= i_payload_len;
        end
    end

    // Slot buffer. Writes come only from the decide step and reads only from the drain
    // walk, which never overlap, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_mem[w_slot_in] <= '{payload: r_in_payload, len: r_in_len, eof: r_in_eof};
        end
        if (w_rd) begin
            r_rd_data <= r_mem[w_slot_exp];
        end
    end

    // Output register: it loads a result whenever the sequencer emits one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind    <= w_kind;
            r_out_ack     <= w_ack;
            r_out_payload <= w_pay;
            r_out_len     <= w_len;
            r_out_eof     <= w_eof;
            r_out_last    <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_ack_seq     = r_out_ack;
    assign o_out_payload = r_out_payload;
    assign o_out_len     = r_out_len;
    assign o_out_eof     = r_out_eof;
    assign o_last        = r_out_last;

    // An accepted packet is always examined in the following cycle.
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == srrw_pkg::S_DECIDE))
        else $error("accepted packet not examined");

    // The drain walk only presents slots whose filled flag is set.
    a_drain_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srrw_pkg::S_DRAIN) |-> r_filled[w_slot_exp])
        else $error("drain of an empty slot");

    // Every delivery advances the expected number by one.
    a_deliver_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (w_kind == srrw_pkg::KIND_DELIVER)) |=> (r_exp == $past(r_exp) + 32'd1))
        else $error("delivery without advance");

    // A result is never emitted while the output register holds an untaken one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || i_ready))
        else $error("output register overwritten");

endmodule
`default_nettype wire
